[hdl/ltbp_pkg.sv]
package ltbp_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_ROW_WIDTH     = 2'd0;
  localparam logic [1:0] REG_ROW_TOTAL     = 2'd1;
  localparam logic [1:0] REG_MAX_LEVEL     = 2'd2;
  localparam logic [1:0] REG_COLOUR_SOURCE = 2'd3;

  localparam int CFG_DATA_W = 13;
  localparam int DIM_CFG_W  = 13;

  // Luma weights; the weighted sum is compared against threshold * LUMA_DIV.
  localparam int LUMA_R   = 299;
  localparam int LUMA_G   = 587;
  localparam int LUMA_B   = 114;
  localparam int LUMA_DIV = 1000;
  localparam int LUMA_W   = 18;

  localparam int BYTE_BITS = 8;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] gray;
  } in_item_t;

  typedef struct packed {
    logic [7:0] packed_byte;
    logic       row_end;
    logic       image_end;
  } out_item_t;

  typedef struct packed {
    logic [7:0] max_level;
    logic       colour_source;
  } pix_cfg_t;

endpackage

[hdl/ltbp_pixel_bit.sv]
module ltbp_pixel_bit (
  input  ltbp_pkg::in_item_t pixel,
  input  ltbp_pkg::pix_cfg_t cfg,
  output logic               dark
);

  logic [7:0]                    thr;
  logic [8:0]                    max_plus;
  logic [ltbp_pkg::LUMA_W-1:0]   luma_sum;
  logic [ltbp_pkg::LUMA_W-1:0]   thr_scaled;

  always_comb begin
    max_plus = {1'b0, cfg.max_level} + 9'd1;
    thr      = max_plus[8:1];
    luma_sum = ltbp_pkg::LUMA_W'(ltbp_pkg::LUMA_R) * ltbp_pkg::LUMA_W'(pixel.red)
             + ltbp_pkg::LUMA_W'(ltbp_pkg::LUMA_G) * ltbp_pkg::LUMA_W'(pixel.green)
             + ltbp_pkg::LUMA_W'(ltbp_pkg::LUMA_B) * ltbp_pkg::LUMA_W'(pixel.blue);
    // floor(sum / 1000) >= thr holds exactly when sum >= thr * 1000.
    thr_scaled = ltbp_pkg::LUMA_W'(ltbp_pkg::LUMA_DIV) * ltbp_pkg::LUMA_W'(thr);
    if (cfg.colour_source) begin
      dark = (luma_sum < thr_scaled);
    end else begin
      dark = (pixel.gray < thr);
    end
  end

endmodule

[hdl/luma_threshold_bit_packer.sv]
// Channel  Direction  Payload                              Handshake
// in       input      in_item  (red, green, blue, gray)    in_valid / in_stall
// out      output     out_item (packed_byte, row_end,      out_valid / out_stall
//                               image_end)
// cfg      input      cfg_index, cfg_data                  cfg_we
//
// One pixel is taken per cycle unless in_stall is high. A pixel is held in the input
// register, then its luma compare and bit append run into the result register, from
// which the byte is offered after its last pixel transfer.
// Reset clears the pixel position, the partial byte and both valid flags and
// loads the register defaults. A stalled result holds the pipeline only when
// the next pixel also completes a byte.
module luma_threshold_bit_packer #(
  parameter int MAX_DIMENSION = 4096
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  ltbp_pkg::in_item_t              in_item,
  output logic                            out_valid,
  input  logic                            out_stall,
  output ltbp_pkg::out_item_t             out_item,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [ltbp_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int CW    = $clog2(MAX_DIMENSION);
  localparam int CMP_W = (CW + 1 > ltbp_pkg::DIM_CFG_W) ? CW + 1 : ltbp_pkg::DIM_CFG_W;

  // Configuration registers.
  logic [ltbp_pkg::DIM_CFG_W-1:0] row_width_r;
  logic [ltbp_pkg::DIM_CFG_W-1:0] row_total_r;
  logic [7:0]                     max_level_r;
  logic                           colour_source_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r     <= ltbp_pkg::DIM_CFG_W'(1);
      row_total_r     <= ltbp_pkg::DIM_CFG_W'(1);
      max_level_r     <= 8'd255;
      colour_source_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        ltbp_pkg::REG_ROW_WIDTH:     row_width_r     <= cfg_data;
        ltbp_pkg::REG_ROW_TOTAL:     row_total_r     <= cfg_data;
        ltbp_pkg::REG_MAX_LEVEL:     max_level_r     <= cfg_data[7:0];
        ltbp_pkg::REG_COLOUR_SOURCE: colour_source_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Input register.
  logic               s1_valid_r;
  logic               s1_valid_nxt;
  ltbp_pkg::in_item_t s1_item_r;

  // Packing state.
  logic [6:0]    acc_r, acc_nxt;
  logic [2:0]    cnt_r, cnt_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [CW-1:0] row_r, row_nxt;

  // Result register.
  logic                out_valid_r, out_valid_nxt;
  ltbp_pkg::out_item_t out_data_r;

  ltbp_pkg::pix_cfg_t pix_cfg;
  logic               dark;

  assign pix_cfg.max_level     = max_level_r;
  assign pix_cfg.colour_source = colour_source_r;

  ltbp_pixel_bit u_pixel_bit (
    .pixel (s1_item_r),
    .cfg   (pix_cfg),
    .dark  (dark)
  );

  logic [CMP_W-1:0] width_c, height_c;
  logic [CMP_W-1:0] col_plus, row_plus;
  logic [7:0]       acc8;
  logic [3:0]       count;
  logic             row_end, image_end, emit, out_free, s1_go, in_accept;
  logic [7:0]       byte_out;

  always_comb begin
    // Zero acts as one, and oversized values saturate to MAX_DIMENSION.
    width_c = CMP_W'(row_width_r);
    if (width_c == '0) begin
      width_c = CMP_W'(1);
    end else if (width_c > CMP_W'(MAX_DIMENSION)) begin
      width_c = CMP_W'(MAX_DIMENSION);
    end
    height_c = CMP_W'(row_total_r);
    if (height_c == '0) begin
      height_c = CMP_W'(1);
    end else if (height_c > CMP_W'(MAX_DIMENSION)) begin
      height_c = CMP_W'(MAX_DIMENSION);
    end

    col_plus  = CMP_W'(col_r) + CMP_W'(1);
    row_plus  = CMP_W'(row_r) + CMP_W'(1);
    row_end   = (col_plus >= width_c);
    image_end = row_end && (row_plus >= height_c);

    acc8     = {acc_r, dark};
    count    = {1'b0, cnt_r} + 4'd1;
    byte_out = 8'(acc8 << (4'(ltbp_pkg::BYTE_BITS) - count));
    emit     = s1_valid_r && (count == 4'(ltbp_pkg::BYTE_BITS) || row_end);

    out_free  = !out_valid_r || !out_stall;
    s1_go     = s1_valid_r && (!emit || out_free);
    in_stall  = s1_valid_r && !s1_go;
    in_accept = in_valid && !in_stall;

    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end

    acc_nxt = acc_r;
    cnt_nxt = cnt_r;
    col_nxt = col_r;
    row_nxt = row_r;
    if (s1_go) begin
      if (row_end) begin
        col_nxt = '0;
        row_nxt = image_end ? '0 : row_plus[CW-1:0];
      end else begin
        col_nxt = col_plus[CW-1:0];
      end
      if (emit) begin
        acc_nxt = '0;
        cnt_nxt = '0;
      end else begin
        acc_nxt = acc8[6:0];
        cnt_nxt = count[2:0];
      end
    end

    out_valid_nxt = out_valid_r;
    if (s1_go && emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
      cnt_r       <= '0;
      col_r       <= '0;
      row_r       <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      acc_r       <= acc_nxt;
      cnt_r       <= cnt_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r <= in_item;
    end
    if (s1_go && emit) begin
      out_data_r.packed_byte <= byte_out;
      out_data_r.row_end     <= row_end;
      out_data_r.image_end   <= image_end;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_data_r;

  a_image_end_in_row : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_data_r.image_end || out_data_r.row_end))
    else $error("image_end set on a byte that does not end a row");

  a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall && emit))
    else $error("input stalled without a blocked byte");

  a_bit_append : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && !emit) |=> (cnt_r == $past(cnt_r) + 3'd1))
    else $error("bit count did not advance on a pixel transfer");

  a_emit_clear : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && emit) |=> (cnt_r == '0 && acc_r == '0 && out_valid_r))
    else $error("partial byte not cleared after a byte was issued");

endmodule

[tb/sv/ltbp_checker.sv]
module ltbp_checker #(
  parameter int MAX_DIMENSION = 4096
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  ltbp_pkg::in_item_t              in_item,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  ltbp_pkg::out_item_t             out_item,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [ltbp_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              mismatches,
  output int                              owed
);

  logic [ltbp_pkg::DIM_CFG_W-1:0] width_reg;
  logic [ltbp_pkg::DIM_CFG_W-1:0] total_reg;
  logic [7:0]                     max_reg;
  logic                           colour_reg;

  logic [6:0]  pending_bits;
  int unsigned bits_held;
  int unsigned col;
  int unsigned row;

  ltbp_pkg::out_item_t expected_bytes[$];

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic int unsigned clamp_dim(input logic [ltbp_pkg::DIM_CFG_W-1:0] v);
    if (v == 0) begin
      return 1;
    end
    if (v > MAX_DIMENSION) begin
      return MAX_DIMENSION;
    end
    return 32'(v);
  endfunction

  function automatic void pack_pixel(input ltbp_pkg::in_item_t px);
    int unsigned         luma;
    int unsigned         cut;
    int unsigned         cnt;
    logic [7:0]          acc;
    logic                row_done;
    logic                img_done;
    ltbp_pkg::out_item_t b;
    if (colour_reg) begin
      luma = (ltbp_pkg::LUMA_R * px.red + ltbp_pkg::LUMA_G * px.green
              + ltbp_pkg::LUMA_B * px.blue) / ltbp_pkg::LUMA_DIV;
    end else begin
      luma = 32'(px.gray);
    end
    cut = (max_reg + 1) / 2;
    // A dark pixel (below the midpoint) appends a one.
    acc = {pending_bits, (luma < cut)};
    cnt = bits_held + 1;
    // The position survives register writes, so the row can already be past the width.
    row_done = (col + 1 >= clamp_dim(width_reg));
    img_done = row_done && (row + 1 >= clamp_dim(total_reg));
    if (row_done) begin
      col = 0;
      row = img_done ? 0 : row + 1;
    end else begin
      col = col + 1;
    end
    if (cnt >= ltbp_pkg::BYTE_BITS || row_done) begin
      b.packed_byte = acc << (ltbp_pkg::BYTE_BITS - cnt);
      b.row_end     = row_done;
      b.image_end   = img_done;
      expected_bytes.push_back(b);
      pending_bits = '0;
      bits_held    = 0;
    end else begin
      pending_bits = acc[6:0];
      bits_held    = cnt;
    end
  endfunction

  task automatic check_byte(input ltbp_pkg::out_item_t got);
    ltbp_pkg::out_item_t want;
    if (expected_bytes.size() == 0) begin
      report_mismatch($sformatf("byte %02h row_end %0b image_end %0b with none expected",
                                got.packed_byte, got.row_end, got.image_end));
    end else begin
      want = expected_bytes.pop_front();
      if (got.packed_byte !== want.packed_byte || got.row_end !== want.row_end ||
          got.image_end !== want.image_end) begin
        report_mismatch($sformatf("byte %02h row_end %0b image_end %0b, expected %02h %0b %0b",
                                  got.packed_byte, got.row_end, got.image_end,
                                  want.packed_byte, want.row_end, want.image_end));
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg    = ltbp_pkg::DIM_CFG_W'(1);
      total_reg    = ltbp_pkg::DIM_CFG_W'(1);
      max_reg      = 8'd255;
      colour_reg   = 1'b1;
      pending_bits = '0;
      bits_held    = 0;
      col          = 0;
      row          = 0;
      mismatches   = 0;
      expected_bytes.delete();
    end else begin
      // A byte leaving now always belongs to an earlier pixel, so compare first.
      if (out_valid && !out_stall) begin
        check_byte(out_item);
      end
      if (cfg_we) begin
        case (cfg_index)
          ltbp_pkg::REG_ROW_WIDTH:     width_reg  = cfg_data[ltbp_pkg::DIM_CFG_W-1:0];
          ltbp_pkg::REG_ROW_TOTAL:     total_reg  = cfg_data[ltbp_pkg::DIM_CFG_W-1:0];
          ltbp_pkg::REG_MAX_LEVEL:     max_reg    = cfg_data[7:0];
          ltbp_pkg::REG_COLOUR_SOURCE: colour_reg = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        pack_pixel(in_item);
      end
    end
    owed = expected_bytes.size();
  end

endmodule

[tb/sv/testbench.sv]
module testbench;

  localparam int MAX_DIMENSION = 4096;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 75;
  localparam int HOLD_CYCLES   = 300;

  logic                            clk       = 1'b0;
  logic                            rst_n     = 1'b0;
  logic                            in_valid  = 1'b0;
  logic                            in_stall;
  ltbp_pkg::in_item_t              in_item   = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  ltbp_pkg::out_item_t             out_item;
  logic                            cfg_we    = 1'b0;
  logic [1:0]                      cfg_index = ltbp_pkg::REG_ROW_WIDTH;
  logic [ltbp_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  logic quiet       = 1'b0;
  int   holds_asked = 0;
  int   level_cut   = 128;
  int   mismatches;
  int   owed;

  luma_threshold_bit_packer #(
    .MAX_DIMENSION(MAX_DIMENSION)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  ltbp_checker #(
    .MAX_DIMENSION(MAX_DIMENSION)
  ) i_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mismatches(mismatches),
    .owed      (owed)
  );

  always #5 clk = ~clk;

  // Result side: random stalls, plus one long hold-off on request from the stimulus.
  initial begin : receiver
    int holds_served;
    holds_served = 0;
    forever begin
      @(posedge clk);
      if (holds_asked != holds_served) begin
        holds_served++;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= !quiet && ($urandom_range(0, 99) < 27);
    end
  end

  task automatic send_pixel(input ltbp_pkg::in_item_t px);
    while (!quiet && $urandom_range(0, 99) < 27) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= px;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
  endtask

  // Waits until every byte has arrived, then lets the pipeline empty of
  // pixels that close no byte.
  task automatic settle();
    in_valid <= 1'b0;
    do begin
      @(negedge clk);
    end while (owed != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(input logic [ltbp_pkg::DIM_CFG_W-1:0] w,
                           input logic [ltbp_pkg::DIM_CFG_W-1:0] h,
                           input logic [7:0] lvl, input logic colour);
    cfg_we    <= 1'b1;
    cfg_index <= ltbp_pkg::REG_ROW_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= ltbp_pkg::REG_ROW_TOTAL;
    cfg_data  <= h;
    @(posedge clk);
    cfg_index <= ltbp_pkg::REG_MAX_LEVEL;
    cfg_data  <= ltbp_pkg::CFG_DATA_W'(lvl);
    @(posedge clk);
    cfg_index <= ltbp_pkg::REG_COLOUR_SOURCE;
    cfg_data  <= ltbp_pkg::CFG_DATA_W'(colour);
    @(posedge clk);
    cfg_we    <= 1'b0;
    level_cut = (lvl + 1) / 2;
  endtask

  // A quarter of the pixels are flat gray right around the threshold; equal
  // channels give that same luma in colour mode.
  function automatic ltbp_pkg::in_item_t random_pixel();
    ltbp_pkg::in_item_t px;
    int                 v;
    px.red   = 8'($urandom_range(0, 255));
    px.green = 8'($urandom_range(0, 255));
    px.blue  = 8'($urandom_range(0, 255));
    px.gray  = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 3) == 0) begin
      v = level_cut + int'($urandom_range(0, 2)) - 1;
      if (v < 0) begin
        v = 0;
      end
      px.red   = 8'(v);
      px.green = 8'(v);
      px.blue  = 8'(v);
      px.gray  = 8'(v);
    end
    return px;
  endfunction

  initial begin : stimulus
    int unsigned w;
    int unsigned h;
    int unsigned lvl;
    logic        colour;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: one pixel per image, colour luma against 128.
    send_pixel('{8'd0, 8'd0, 8'd0, 8'd0});
    send_pixel('{8'd255, 8'd255, 8'd255, 8'd255});
    send_pixel('{8'd128, 8'd128, 8'd128, 8'd0});
    send_pixel('{8'd127, 8'd127, 8'd127, 8'd255});
    send_pixel('{8'd255, 8'd0, 8'd0, 8'd0});
    send_pixel('{8'd0, 8'd255, 8'd0, 8'd0});
    send_pixel('{8'd0, 8'd0, 8'd255, 8'd255});

    // Zero width and height act as one; gray mode ignores the colour channels.
    settle();
    configure(13'd0, 13'd0, 8'd255, 1'b0);
    send_pixel('{8'd0, 8'd0, 8'd0, 8'd128});
    send_pixel('{8'd255, 8'd255, 8'd255, 8'd127});
    send_pixel('{8'd255, 8'd255, 8'd255, 8'd0});

    // Zero max level makes every pixel light. Seven pixels of a 3x2 image run
    // past the image end and start the next one.
    settle();
    configure(13'd3, 13'd2, 8'd0, 1'b0);
    send_pixel('{8'd0, 8'd0, 8'd0, 8'd0});
    send_pixel('{8'd0, 8'd0, 8'd0, 8'd0});
    send_pixel('{8'd0, 8'd0, 8'd0, 8'd255});
    send_pixel('{8'd0, 8'd0, 8'd0, 8'd0});
    send_pixel('{8'd0, 8'd0, 8'd0, 8'd0});
    send_pixel('{8'd0, 8'd0, 8'd0, 8'd0});
    send_pixel('{8'd0, 8'd0, 8'd0, 8'd0});

    // Width shrinks below the current column mid-row; oversized height saturates.
    settle();
    configure(13'd1, 13'd8191, 8'd1, 1'b1);
    send_pixel('{8'd0, 8'd0, 8'd0, 8'd0});
    send_pixel('{8'd1, 8'd1, 8'd1, 8'd0});
    send_pixel('{8'd0, 8'd2, 8'd0, 8'd0});
    send_pixel('{8'd3, 8'd0, 8'd0, 8'd255});

    for (int p = 0; p < PHASES; p++) begin
      settle();
      w      = $urandom_range(1, 20);
      h      = $urandom_range(1, 5);
      lvl    = $urandom_range(0, 255);
      colour = 1'($urandom_range(0, 1));
      case (p)
        0: begin
          w = 8;
          h = 3;
        end
        1: begin
          w   = 8191;
          h   = 8191;
          lvl = 255;
        end
        2: begin
          w = 5;
          h = 4;
        end
        3: begin
          w   = 0;
          h   = 0;
          lvl = 1;
        end
        4: begin
          w = 4097;
          h = 2;
        end
        default: ;
      endcase
      configure(ltbp_pkg::DIM_CFG_W'(w), ltbp_pkg::DIM_CFG_W'(h), 8'(lvl), colour);
      if (p == 0 || p == 2) begin
        quiet <= 1'b1;
      end
      // The result side holds off while pixels keep coming, so the block backs up.
      if (p == 2) begin
        holds_asked <= holds_asked + 1;
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_pixel(random_pixel());
      end
      quiet <= 1'b0;
    end

    settle();
    @(negedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule
